>>> rtl/pse_pkg.sv
`default_nettype none

package pse_pkg;

    localparam int SIEVE_DEPTH = 1048576;
    localparam int FIELD_W     = 20;
    localparam int COUNT_W     = 17;
    localparam int FIRST_PRIME = 2;

    localparam logic REQ_BUILD = 1'b0;
    localparam logic REQ_QUERY = 1'b1;

    typedef enum logic [1:0] {
        ADDR_I,
        ADDR_J,
        ADDR_NUM
    } addr_sel_t;

    typedef struct packed {
        logic      capture;
        logic      i_zero;
        logic      i_first;
        logic      i_inc;
        logic      j_load;
        logic      j_step;
        logic      wr_en;
        logic      wr_cand;
        logic      rd_en;
        logic      count_rd;
        addr_sel_t addr_sel;
        logic      out_build;
        logic      out_query;
    } pse_cmd_t;

    typedef struct packed {
        logic i_le_lim;
        logic i_le_half;
        logic j_le_lim;
        logic rd_bit;
        logic out_free;
    } pse_stat_t;

endpackage

`default_nettype wire

>>> rtl/pse_ram.sv
`default_nettype none

module pse_ram #(
    parameter int WIDTH = 1,
    parameter int DEPTH = 64
) (
    input  wire logic                     aclk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic                     rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

>>> rtl/pse_dp.sv
`default_nettype none

module pse_dp #(
    parameter int SIEVE_DEPTH = pse_pkg::SIEVE_DEPTH
) (
    input  wire logic                         aclk,
    input  wire logic                         aresetn,
    input  wire pse_pkg::pse_cmd_t            cmd,
    output pse_pkg::pse_stat_t                stat,
    input  wire logic [pse_pkg::FIELD_W-1:0]  s_limit,
    input  wire logic [pse_pkg::FIELD_W-1:0]  s_number,
    output logic                              m_valid,
    input  wire logic                         m_ready,
    output logic      [pse_pkg::COUNT_W-1:0]  m_prime_count,
    output logic                              m_is_prime_flag
);

    localparam int AW = $clog2(SIEVE_DEPTH);
    localparam int CW = ((AW > pse_pkg::FIELD_W) ? AW : pse_pkg::FIELD_W) + 1;

    logic [CW-1:0]               lim_reg, num_reg, i_reg, j_reg;
    logic [CW-1:0]               lim_ext, lim_sat;
    logic [pse_pkg::COUNT_W-1:0] count_reg;
    logic [pse_pkg::FIELD_W-1:0] built_limit_reg;
    logic                        built_valid_reg;
    logic [pse_pkg::COUNT_W-1:0] last_count_reg;
    logic                        rd_pend_reg;
    logic                        m_valid_reg;
    logic [pse_pkg::COUNT_W-1:0] m_prime_count_reg;
    logic                        m_flag_reg;
    logic [CW-1:0]               addr_cw;
    logic [AW-1:0]               addr;
    logic                        wr_bit;
    logic                        rd_bit;

    assign lim_ext = CW'(s_limit);
    assign lim_sat = (lim_ext > CW'(SIEVE_DEPTH - 1)) ? CW'(SIEVE_DEPTH - 1) : lim_ext;

    always_comb begin
        unique case (cmd.addr_sel)
            pse_pkg::ADDR_I:   addr_cw = i_reg;
            pse_pkg::ADDR_J:   addr_cw = j_reg;
            pse_pkg::ADDR_NUM: addr_cw = num_reg;
            default:           addr_cw = i_reg;
        endcase
    end

    assign addr   = addr_cw[AW-1:0];
    assign wr_bit = cmd.wr_cand && (i_reg >= CW'(pse_pkg::FIRST_PRIME));

    pse_ram #(
        .WIDTH (1),
        .DEPTH (SIEVE_DEPTH)
    ) u_sieve_ram (
        .aclk    (aclk),
        .wr_en   (cmd.wr_en),
        .wr_addr (addr),
        .wr_data (wr_bit),
        .rd_en   (cmd.rd_en),
        .rd_addr (addr),
        .rd_data (rd_bit)
    );

    always_comb begin
        stat.i_le_lim  = (i_reg <= lim_reg);
        stat.i_le_half = (i_reg <= (lim_reg >> 1));
        stat.j_le_lim  = (j_reg <= lim_reg);
        stat.rd_bit    = rd_bit;
        stat.out_free  = !m_valid_reg || m_ready;
    end

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            built_valid_reg <= 1'b0;
            built_limit_reg <= '0;
            last_count_reg  <= '0;
            rd_pend_reg     <= 1'b0;
            m_valid_reg     <= 1'b0;
        end else begin
            rd_pend_reg <= cmd.rd_en && cmd.count_rd;
            if (cmd.out_build) begin
                built_valid_reg <= 1'b1;
                built_limit_reg <= lim_reg[pse_pkg::FIELD_W-1:0];
                last_count_reg  <= count_reg;
            end
            if (cmd.out_build || cmd.out_query) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // datapath payload
    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            lim_reg <= lim_sat;
            num_reg <= CW'(s_number);
        end
        if (cmd.i_zero) begin
            i_reg <= '0;
        end else if (cmd.i_first) begin
            i_reg <= CW'(pse_pkg::FIRST_PRIME);
        end else if (cmd.i_inc) begin
            i_reg <= i_reg + CW'(1);
        end
        if (cmd.j_load) begin
            j_reg <= {i_reg[CW-2:0], 1'b0};
        end else if (cmd.j_step) begin
            j_reg <= j_reg + i_reg;
        end
        if (cmd.i_first) begin
            count_reg <= '0;
        end else if (rd_pend_reg && rd_bit) begin
            count_reg <= count_reg + pse_pkg::COUNT_W'(1);
        end
        if (cmd.out_build) begin
            m_prime_count_reg <= count_reg;
            m_flag_reg        <= 1'b0;
        end else if (cmd.out_query) begin
            m_prime_count_reg <= last_count_reg;
            m_flag_reg        <= built_valid_reg && rd_bit
                                 && (num_reg <= CW'(built_limit_reg));
        end
    end

    assign m_valid         = m_valid_reg;
    assign m_prime_count   = m_prime_count_reg;
    assign m_is_prime_flag = m_flag_reg;

endmodule

`default_nettype wire

>>> rtl/pse_ctrl.sv
`default_nettype none

module pse_ctrl (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               s_valid,
    output logic                    s_ready,
    input  wire logic               s_req_type,
    input  wire pse_pkg::pse_stat_t stat,
    output pse_pkg::pse_cmd_t       cmd
);

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_Q_RD,
        ST_Q_OUT,
        ST_INIT,
        ST_O_TEST,
        ST_O_WAIT,
        ST_INNER,
        ST_C_RUN,
        ST_C_DRAIN,
        ST_B_OUT
    } state_t;

    state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next   = state_reg;
        cmd          = '0;
        cmd.addr_sel = pse_pkg::ADDR_I;
        s_ready      = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.capture = 1'b1;
                    cmd.i_zero  = 1'b1;
                    state_next  = (s_req_type == pse_pkg::REQ_QUERY) ? ST_Q_RD : ST_INIT;
                end
            end
            ST_Q_RD: begin
                cmd.rd_en    = 1'b1;
                cmd.addr_sel = pse_pkg::ADDR_NUM;
                state_next   = ST_Q_OUT;
            end
            ST_Q_OUT: begin
                if (stat.out_free) begin
                    cmd.out_query = 1'b1;
                    state_next    = ST_IDLE;
                end
            end
            ST_INIT: begin
                // mark 0 and 1 composite, everything else a candidate
                if (stat.i_le_lim) begin
                    cmd.wr_en   = 1'b1;
                    cmd.wr_cand = 1'b1;
                    cmd.i_inc   = 1'b1;
                end else begin
                    cmd.i_first = 1'b1;
                    state_next  = ST_O_TEST;
                end
            end
            ST_O_TEST: begin
                if (stat.i_le_half) begin
                    cmd.rd_en  = 1'b1;
                    state_next = ST_O_WAIT;
                end else begin
                    cmd.i_first = 1'b1;
                    state_next  = ST_C_RUN;
                end
            end
            ST_O_WAIT: begin
                if (stat.rd_bit) begin
                    cmd.j_load = 1'b1;
                    state_next = ST_INNER;
                end else begin
                    cmd.i_inc  = 1'b1;
                    state_next = ST_O_TEST;
                end
            end
            ST_INNER: begin
                if (stat.j_le_lim) begin
                    cmd.wr_en    = 1'b1;
                    cmd.addr_sel = pse_pkg::ADDR_J;
                    cmd.j_step   = 1'b1;
                end else begin
                    cmd.i_inc  = 1'b1;
                    state_next = ST_O_TEST;
                end
            end
            ST_C_RUN: begin
                // one read issued per cycle, accumulated in the next cycle
                if (stat.i_le_lim) begin
                    cmd.rd_en    = 1'b1;
                    cmd.count_rd = 1'b1;
                    cmd.i_inc    = 1'b1;
                end else begin
                    state_next = ST_C_DRAIN;
                end
            end
            ST_C_DRAIN: begin
                state_next = ST_B_OUT;
            end
            ST_B_OUT: begin
                if (stat.out_free) begin
                    cmd.out_build = 1'b1;
                    state_next    = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

>>> rtl/prime_sieve_engine_core.sv
`default_nettype none

// Sieve of Eratosthenes engine over a one-bit-per-entry table in a single
// simple dual-port RAM.
// Input channel (s_*): req_type selects a build up to s_limit or a primality
// query of s_number. Result channel (m_*): one transaction per request,
// carrying m_prime_count and m_is_prime_flag.
// One request is worked at a time; s_ready is high only while the controller
// is idle, and an unread result sits in the output register meanwhile.
// Query: acceptance is followed by one registered RAM read of the table bit,
// then the result enters the output register once it is free, and the
// controller returns to idle. Build with limit L: (L+1) init writes, a test
// read per outer candidate up to L/2, one write per cleared multiple of each
// sieving prime, then (L-1) count reads. Limits beyond the table saturate to
// SIEVE_DEPTH-1.
// Reset returns to idle with no sieve built; queries then report not prime
// and a count of zero. The table needs no clearing pass.
// If m_ready stays low, the finished result holds and the engine waits
// before writing the next one.
module prime_sieve_engine_core #(
    parameter int SIEVE_DEPTH = pse_pkg::SIEVE_DEPTH
) (
    input  wire logic                         aclk,
    input  wire logic                         aresetn,
    input  wire logic                         s_valid,
    output logic                              s_ready,
    input  wire logic                         s_req_type,
    input  wire logic [pse_pkg::FIELD_W-1:0]  s_limit,
    input  wire logic [pse_pkg::FIELD_W-1:0]  s_number,
    output logic                              m_valid,
    input  wire logic                         m_ready,
    output logic      [pse_pkg::COUNT_W-1:0]  m_prime_count,
    output logic                              m_is_prime_flag
);

    pse_pkg::pse_cmd_t  cmd;
    pse_pkg::pse_stat_t stat;

    pse_ctrl u_ctrl (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_req_type (s_req_type),
        .stat       (stat),
        .cmd        (cmd)
    );

    pse_dp #(
        .SIEVE_DEPTH (SIEVE_DEPTH)
    ) u_dp (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cmd             (cmd),
        .stat            (stat),
        .s_limit         (s_limit),
        .s_number        (s_number),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_prime_count   (m_prime_count),
        .m_is_prime_flag (m_is_prime_flag)
    );

endmodule

`default_nettype wire

>>> tb/tb_prime_sieve_engine_core.sv
`timescale 1ns / 1ps

module tb_prime_sieve_engine_core;

    localparam int unsigned STALL_LIMIT  = 40_000_000;
    localparam int unsigned DRAIN_CYCLES = 16;
    localparam int unsigned MAX_LIMIT    = pse_pkg::SIEVE_DEPTH - 1;
    localparam int          FW           = pse_pkg::FIELD_W;
    localparam int          CNTW         = pse_pkg::COUNT_W;

    typedef struct packed {
        logic [CNTW-1:0] prime_count;
        logic            prime_flag;
    } sieve_answer_t;

    logic            aclk = 1'b0;
    logic            aresetn = 1'b0;
    logic            s_valid = 1'b0;
    logic            s_ready;
    logic            s_req_type = pse_pkg::REQ_BUILD;
    logic [FW-1:0]   s_limit = '0;
    logic [FW-1:0]   s_number = '0;
    logic            m_valid;
    logic            m_ready = 1'b0;
    logic [CNTW-1:0] m_prime_count;
    logic            m_is_prime_flag;

    // shadow of the engine state
    bit              prime_marks [0:pse_pkg::SIEVE_DEPTH-1];
    logic [FW-1:0]   shadow_limit = '0;
    bit              shadow_built = 1'b0;
    logic [CNTW-1:0] shadow_count = '0;

    sieve_answer_t   predicted_answers [$];
    int unsigned     mismatch_count = 0;
    int unsigned     idle_pct = 0;
    int unsigned     stall_pct = 0;
    int unsigned     quiet_cycles = 0;

    prime_sieve_engine_core u_top (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_req_type      (s_req_type),
        .s_limit         (s_limit),
        .s_number        (s_number),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_prime_count   (m_prime_count),
        .m_is_prime_flag (m_is_prime_flag)
    );

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    always @(negedge aclk) begin
        m_ready = ($urandom_range(0, 99) >= stall_pct);
    end

    function automatic sieve_answer_t sieve_predict(input logic req,
                                                    input logic [FW-1:0] lim,
                                                    input logic [FW-1:0] num);
        sieve_answer_t ans;
        int unsigned   top;
        int unsigned   i;
        int unsigned   j;
        int unsigned   survivors;
        ans = '0;
        if (req == pse_pkg::REQ_BUILD) begin
            top = lim;
            if (top > MAX_LIMIT)
                top = MAX_LIMIT;
            for (i = 0; i <= top; i++)
                prime_marks[i] = (i >= pse_pkg::FIRST_PRIME);
            for (i = pse_pkg::FIRST_PRIME; i <= top / 2; i++) begin
                if (prime_marks[i]) begin
                    for (j = 2 * i; j <= top; j += i)
                        prime_marks[j] = 1'b0;
                end
            end
            survivors = 0;
            for (i = pse_pkg::FIRST_PRIME; i <= top; i++)
                survivors += prime_marks[i];
            shadow_count = survivors[CNTW-1:0];
            shadow_limit = top[FW-1:0];
            shadow_built = 1'b1;
            ans.prime_count = shadow_count;
        end else begin
            ans.prime_count = shadow_built ? shadow_count : '0;
            ans.prime_flag  = shadow_built && (num <= shadow_limit) && prime_marks[num];
        end
        return ans;
    endfunction

    // Ends right after the accepting edge with s_valid still high.
    task automatic send_request(input logic req, input logic [FW-1:0] lim,
                                input logic [FW-1:0] num);
        @(negedge aclk);
        while ($urandom_range(0, 99) < idle_pct) begin
            s_valid = 1'b0;
            @(negedge aclk);
        end
        s_req_type = req;
        s_limit    = lim;
        s_number   = num;
        s_valid    = 1'b1;
        while (!s_ready)
            @(negedge aclk);
        @(posedge aclk);
        predicted_answers.push_back(sieve_predict(req, lim, num));
    endtask

    task automatic hold_until_drained();
        @(negedge aclk);
        s_valid = 1'b0;
        while (predicted_answers.size() != 0)
            @(negedge aclk);
    endtask

    function automatic logic [FW-1:0] pick_number();
        int unsigned roll;
        roll = $urandom_range(0, 99);
        if (roll < 60)
            return FW'($urandom_range(0, shadow_limit));
        else if (roll < 80)
            return FW'(shadow_limit + $urandom_range(0, 3));
        return FW'($urandom());
    endfunction

    always @(posedge aclk) begin
        sieve_answer_t want;
        if (aresetn && m_valid && m_ready) begin
            if (predicted_answers.size() == 0) begin
                $display("%0t: unexpected result: count %0d, flag %0d",
                         $time, m_prime_count, m_is_prime_flag);
                mismatch_count++;
            end else begin
                want = predicted_answers.pop_front();
                if (m_prime_count !== want.prime_count) begin
                    $display("%0t: prime_count mismatch: expected %0d, actual %0d",
                             $time, want.prime_count, m_prime_count);
                    mismatch_count++;
                end
                if (m_is_prime_flag !== want.prime_flag) begin
                    $display("%0t: is_prime_flag mismatch: expected %0d, actual %0d",
                             $time, want.prime_flag, m_is_prime_flag);
                    mismatch_count++;
                end
            end
        end
    end

    // a full-table build passes no transaction while it runs
    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= STALL_LIMIT) begin
            $display("%0t: timeout, %0d results outstanding", $time,
                     predicted_answers.size());
            $display("DONE: errors detected");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    task automatic test_query_before_build();
        send_request(pse_pkg::REQ_QUERY, FW'($urandom()), '0);
        send_request(pse_pkg::REQ_QUERY, FW'($urandom()), FW'(pse_pkg::FIRST_PRIME));
        send_request(pse_pkg::REQ_QUERY, FW'($urandom()), '1);
    endtask

    task automatic test_tiny_limits();
        send_request(pse_pkg::REQ_BUILD, '0, FW'($urandom()));
        send_request(pse_pkg::REQ_QUERY, FW'($urandom()), '0);
        send_request(pse_pkg::REQ_BUILD, FW'(1), FW'($urandom()));
        send_request(pse_pkg::REQ_QUERY, FW'($urandom()), FW'(1));
        send_request(pse_pkg::REQ_BUILD, FW'(2), FW'($urandom()));
        send_request(pse_pkg::REQ_QUERY, FW'($urandom()), FW'(2));
        send_request(pse_pkg::REQ_QUERY, FW'($urandom()), FW'(3));
        send_request(pse_pkg::REQ_BUILD, FW'(3), FW'($urandom()));
        send_request(pse_pkg::REQ_QUERY, FW'($urandom()), FW'(3));
    endtask

    task automatic test_limit_boundary();
        send_request(pse_pkg::REQ_BUILD, FW'(100), FW'($urandom()));
        send_request(pse_pkg::REQ_QUERY, FW'($urandom()), FW'(97));
        send_request(pse_pkg::REQ_QUERY, FW'($urandom()), FW'(99));
        send_request(pse_pkg::REQ_QUERY, FW'($urandom()), FW'(100));
        send_request(pse_pkg::REQ_QUERY, FW'($urandom()), FW'(101));
    endtask

    task automatic test_full_table(input int unsigned n_queries);
        send_request(pse_pkg::REQ_BUILD, '1, '0);
        send_request(pse_pkg::REQ_QUERY, '0, FW'(MAX_LIMIT - 2));
        send_request(pse_pkg::REQ_QUERY, '0, '1);
        send_request(pse_pkg::REQ_QUERY, '1, '0);
        send_request(pse_pkg::REQ_QUERY, '1, FW'(pse_pkg::FIRST_PRIME));
        repeat (n_queries)
            send_request(pse_pkg::REQ_QUERY, FW'($urandom()), FW'($urandom()));
        hold_until_drained();
    endtask

    task automatic test_mixed_traffic(input int unsigned send_idle,
                                      input int unsigned recv_stall,
                                      input int unsigned n_items);
        int unsigned lim;
        idle_pct  = send_idle;
        stall_pct = recv_stall;
        repeat (n_items) begin
            if ($urandom_range(0, 99) == 0)
                hold_until_drained();
            if ($urandom_range(0, 99) < 4) begin
                if ($urandom_range(0, 2) == 0)
                    hold_until_drained();
                lim = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 3000)
                                                  : $urandom_range(0, 300);
                send_request(pse_pkg::REQ_BUILD, lim[FW-1:0], FW'($urandom()));
            end else begin
                send_request(pse_pkg::REQ_QUERY, FW'($urandom()), pick_number());
            end
        end
        hold_until_drained();
    endtask

    initial begin
        repeat (8) @(negedge aclk);
        aresetn = 1'b1;

        test_query_before_build();
        test_tiny_limits();
        test_limit_boundary();
        test_full_table(200);
        test_mixed_traffic(0, 0, 450);
        test_mixed_traffic(55, 0, 450);
        test_mixed_traffic(0, 55, 450);
        test_mixed_traffic(33, 33, 450);

        hold_until_drained();
        repeat (DRAIN_CYCLES) @(negedge aclk);
        if (mismatch_count == 0 && predicted_answers.size() == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
